// ===== rtl/pdss_pkg.sv =====
// Shared types, constants and helpers for the saturating pixel divider.
`timescale 1ns / 1ps
`default_nettype none
package pdss_pkg;

  localparam int SCALE_FRAC_BITS = 16;
  localparam int QB = 33;  // quotient bits worked out by the cell row

  localparam logic [2:0] PT_U8  = 3'd0;
  localparam logic [2:0] PT_S8  = 3'd1;
  localparam logic [2:0] PT_U16 = 3'd2;
  localparam logic [2:0] PT_S16 = 3'd3;
  localparam logic [2:0] PT_S32 = 3'd4;

  localparam logic REG_PIXEL_TYPE   = 1'b0;
  localparam logic REG_SCALE_FACTOR = 1'b1;

  localparam logic [31:0] SCALE_RESET = 32'd65536;

  typedef struct packed {
    logic        vld;
    logic [31:0] rem;
    logic [QB-1:0] low;
    logic [QB-1:0] quo;
    logic [31:0] den;
    logic        neg;
    logic        dz;
    logic        azero;
    logic        ovf;
    logic [2:0]  ptype;
  } cell_t;

  function automatic logic [32:0] type_hi(input logic [2:0] t);
    case (t)
      PT_U8:   type_hi = 33'd255;
      PT_S8:   type_hi = 33'd127;
      PT_U16:  type_hi = 33'd65535;
      PT_S16:  type_hi = 33'd32767;
      default: type_hi = 33'h07FFFFFFF;
    endcase
  endfunction

  function automatic logic [32:0] type_lo_mag(input logic [2:0] t);
    case (t)
      PT_U8:   type_lo_mag = 33'd0;
      PT_S8:   type_lo_mag = 33'd128;
      PT_U16:  type_lo_mag = 33'd0;
      PT_S16:  type_lo_mag = 33'd32768;
      default: type_lo_mag = 33'h080000000;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pdss_cell.sv =====
// One restoring-division cell: brings down one numerator bit, yields one quotient bit.
`timescale 1ns / 1ps
`default_nettype none
module pdss_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  pdss_pkg::cell_t     din,
  output pdss_pkg::cell_t     dout
);

  logic [32:0] trial;
  logic [32:0] diff;
  logic        take;
  pdss_pkg::cell_t nxt;

  always_comb begin
    trial = {din.rem, din.low[pdss_pkg::QB-1]};
    diff  = trial - {1'b0, din.den};
    take  = (trial >= {1'b0, din.den});
    nxt = din;
    nxt.rem = take ? diff[31:0] : trial[31:0];
    nxt.low = {din.low[pdss_pkg::QB-2:0], 1'b0};
    nxt.quo = {din.quo[pdss_pkg::QB-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
    if (rst) begin
      dout.vld <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pixel_divide_scale_saturate.sv =====
// Top level: saturating scaled pixel divider, pipelined through a row of division cells.
//
//  channel | signals                                   | direction
//  s_axis  | s_axis_tvalid/tready/tdata[63:0]          | in: dividend, divisor
//  m_axis  | m_axis_tvalid/tready/tdata[31:0]/tuser[1:0]| out: quotient; clipped, divide_by_zero
//  cfg     | cfg_valid/cfg_ready/cfg_index/cfg_data    | in: register writes
//
// One beat in and one beat out per cycle while m_axis is not stalled; the pipeline registers are extend,
// multiply, prepare, 33 division cells and the output register, with one quotient bit per division cell.
// Synchronous reset clears valid bits and loads the register reset values.
// A stall on m_axis freezes the whole pipeline; s_axis_tready follows it.
`timescale 1ns / 1ps
`default_nettype none
module pixel_divide_scale_saturate #(
  parameter int SCALE_FRAC_BITS = pdss_pkg::SCALE_FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // dividend[31:0], divisor[63:32]
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,   // quotient[31:0]
  output      logic [1:0]  m_axis_tuser,   // clipped[0], divide_by_zero[1]
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int QB = pdss_pkg::QB;

  logic [2:0]  pixel_type;
  logic [31:0] scale_factor;
  logic        en;

  assign cfg_ready     = 1'b1;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_type   <= pdss_pkg::PT_U8;
      scale_factor <= pdss_pkg::SCALE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        pdss_pkg::REG_PIXEL_TYPE:   pixel_type   <= cfg_data[2:0];
        pdss_pkg::REG_SCALE_FACTOR: scale_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: operand extension per pixel type, then magnitudes, result sign and zero flags
  logic [31:0] a_ext, b_ext;
  always_comb begin
    case (pixel_type)
      pdss_pkg::PT_U8: begin
        a_ext = {24'd0, s_axis_tdata[7:0]};
        b_ext = {24'd0, s_axis_tdata[39:32]};
      end
      pdss_pkg::PT_S8: begin
        a_ext = {{24{s_axis_tdata[7]}}, s_axis_tdata[7:0]};
        b_ext = {{24{s_axis_tdata[39]}}, s_axis_tdata[39:32]};
      end
      pdss_pkg::PT_U16: begin
        a_ext = {16'd0, s_axis_tdata[15:0]};
        b_ext = {16'd0, s_axis_tdata[47:32]};
      end
      pdss_pkg::PT_S16: begin
        a_ext = {{16{s_axis_tdata[15]}}, s_axis_tdata[15:0]};
        b_ext = {{16{s_axis_tdata[47]}}, s_axis_tdata[47:32]};
      end
      default: begin
        a_ext = s_axis_tdata[31:0];
        b_ext = s_axis_tdata[63:32];
      end
    endcase
  end

  logic        s1_vld;
  logic [31:0] s1_maga, s1_magb, s1_mags;
  logic        s1_neg, s1_dz, s1_azero;
  logic [2:0]  s1_ptype;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_vld   <= s_axis_tvalid;
      s1_maga  <= a_ext[31] ? (32'd0 - a_ext) : a_ext;
      s1_magb  <= b_ext[31] ? (32'd0 - b_ext) : b_ext;
      s1_mags  <= scale_factor[31] ? (32'd0 - scale_factor) : scale_factor;
      s1_neg   <= a_ext[31] ^ scale_factor[31] ^ b_ext[31];
      s1_dz    <= (b_ext == 32'd0);
      s1_azero <= (a_ext == 32'd0);
      s1_ptype <= pixel_type;
    end
    if (rst) s1_vld <= 1'b0;
  end

  // stage 2: |a| * |s|
  logic        s2_vld;
  logic [63:0] s2_num;
  logic [31:0] s2_magb;
  logic        s2_neg, s2_dz, s2_azero;
  logic [2:0]  s2_ptype;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_vld   <= s1_vld;
      s2_num   <= s1_maga * s1_mags;
      s2_magb  <= s1_magb;
      s2_neg   <= s1_neg;
      s2_dz    <= s1_dz;
      s2_azero <= s1_azero;
      s2_ptype <= s1_ptype;
    end
    if (rst) s2_vld <= 1'b0;
  end

  // stage 3: rounded numerator, scaled down so the divisor is plain |b|
  logic [65:0] nsum;
  logic [65:0] nshift;
  logic [31:0] upper;
  pdss_pkg::cell_t prep;
  pdss_pkg::cell_t chain [0:QB];

  always_comb begin
    nsum   = {1'b0, s2_num, 1'b0} + ({34'd0, s2_magb} << SCALE_FRAC_BITS);
    nshift = nsum >> (SCALE_FRAC_BITS + 1);
    upper  = nshift[QB+31:QB];
    prep.vld   = s2_vld;
    prep.ovf   = (upper >= s2_magb);
    prep.rem   = upper;
    prep.low   = nshift[QB-1:0];
    prep.quo   = '0;
    prep.den   = s2_magb;
    prep.neg   = s2_neg;
    prep.dz    = s2_dz;
    prep.azero = s2_azero;
    prep.ptype = s2_ptype;
  end

  always_ff @(posedge clk) begin
    if (en) chain[0] <= prep;
    if (rst) chain[0].vld <= 1'b0;
  end

  for (genvar i = 0; i < QB; i++) begin : g_cell
    pdss_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // output stage: zero-divisor result, sign and clipping of the rounded quotient
  pdss_pkg::cell_t fin;
  logic [32:0] hi, lo_mag, qv;
  logic [31:0] res;
  logic        clip;

  always_comb begin
    fin    = chain[QB];
    hi     = pdss_pkg::type_hi(fin.ptype);
    lo_mag = pdss_pkg::type_lo_mag(fin.ptype);
    qv     = fin.quo;
    clip   = 1'b0;
    if (fin.dz) begin
      res = fin.azero ? 32'd0 : hi[31:0];
    end else if (fin.ovf) begin
      clip = 1'b1;
      res  = fin.neg ? (32'd0 - lo_mag[31:0]) : hi[31:0];
    end else if (qv == 33'd0) begin
      res = 32'd0;
    end else if (fin.neg) begin
      if (qv > lo_mag) begin
        clip = 1'b1;
        res  = 32'd0 - lo_mag[31:0];
      end else begin
        res = 32'd0 - qv[31:0];
      end
    end else begin
      if (qv > hi) begin
        clip = 1'b1;
        res  = hi[31:0];
      end else begin
        res = qv[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tvalid <= fin.vld;
      m_axis_tdata  <= res;
      m_axis_tuser  <= {fin.dz, clip};
    end
    if (rst) m_axis_tvalid <= 1'b0;
  end

endmodule
`default_nettype wire

// ===== tb/tb_pixel_divide_scale_saturate.sv =====
// Testbench for the saturating scaled pixel divider: random and directed pixel pairs.
`timescale 1ns / 1ps
module tb_pixel_divide_scale_saturate;

  typedef struct {
    logic [31:0] quotient;
    logic        clipped;
    logic        divide_by_zero;
  } quot_t;

  int errors = 0;

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    errors++;
  endtask

  class divide_scoreboard;
    logic [2:0]  ptype;
    logic [31:0] scale;
    quot_t       pending[$];

    function new();
      ptype = pdss_pkg::PT_U8;
      scale = pdss_pkg::SCALE_RESET;
    endfunction

    function quot_t divide(input logic [31:0] dvd, input logic [31:0] dvs);
      quot_t r;
      longint a, b, s, lo, hi, qs;
      logic [63:0] num, den, q, am, bm, sm;
      bit neg;
      case (ptype)
        pdss_pkg::PT_U8: begin
          a = longint'(dvd[7:0]); b = longint'(dvs[7:0]); lo = 0; hi = 255;
        end
        pdss_pkg::PT_S8: begin
          a = longint'($signed(dvd[7:0])); b = longint'($signed(dvs[7:0]));
          lo = -128; hi = 127;
        end
        pdss_pkg::PT_U16: begin
          a = longint'(dvd[15:0]); b = longint'(dvs[15:0]); lo = 0; hi = 65535;
        end
        pdss_pkg::PT_S16: begin
          a = longint'($signed(dvd[15:0])); b = longint'($signed(dvs[15:0]));
          lo = -32768; hi = 32767;
        end
        default: begin
          a = longint'($signed(dvd)); b = longint'($signed(dvs));
          lo = -64'sd2147483648; hi = 2147483647;
        end
      endcase
      r.clipped = 0;
      r.divide_by_zero = 0;
      if (b == 0) begin
        r.divide_by_zero = 1;
        qs = (a == 0) ? 0 : hi;
      end else begin
        s = longint'($signed(scale));
        am = (a < 0) ? -a : a;
        bm = (b < 0) ? -b : b;
        sm = (s < 0) ? -s : s;
        num = am * sm;
        den = bm << pdss_pkg::SCALE_FRAC_BITS;
        q = (2 * num + den) / (2 * den);
        neg = ((a < 0) != (s < 0)) != (b < 0);
        if (q == 0) qs = 0;
        else if (neg) begin
          if (q > -lo) begin qs = lo; r.clipped = 1; end
          else qs = -longint'(q);
        end else begin
          if (q > hi) begin qs = hi; r.clipped = 1; end
          else qs = q;
        end
      end
      r.quotient = qs[31:0];
      return r;
    endfunction

    function void note_input(input logic [63:0] d);
      pending.push_back(divide(d[31:0], d[63:32]));
    endfunction

    task check_result(input logic [31:0] q, input logic [1:0] u);
      quot_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat q=%h", q));
        return;
      end
      e = pending.pop_front();
      if (q !== e.quotient) report($sformatf("quotient %h, want %h", q, e.quotient));
      if (u[0] !== e.clipped) report($sformatf("clipped %b, want %b", u[0], e.clipped));
      if (u[1] !== e.divide_by_zero)
        report($sformatf("divide_by_zero %b, want %b", u[1], e.divide_by_zero));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, m_axis_tready = 0, cfg_valid = 0, cfg_index = 0;
  logic [63:0] s_axis_tdata = '0;
  logic [31:0] cfg_data = '0;
  logic s_axis_tready, m_axis_tvalid, cfg_ready;
  logic [31:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  bit calm = 0;
  divide_scoreboard sb = new();

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  pixel_divide_scale_saturate dut (.*);

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 0;
        n = $urandom_range(1, 12);
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1;
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_beat(input logic [31:0] dvd, input logic [31:0] dvs);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 0;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {dvs, dvd};
    @(posedge clk iff s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 0;
    if (idx == pdss_pkg::REG_PIXEL_TYPE) sb.ptype = val[2:0];
    else sb.scale = val;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 8);
      5: return -$urandom_range(1, 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3: return 32'd65536;
      4: return -32'sd65536;
      5: return $urandom_range(0, 262144);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] dirs[12] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7F, 32'h80, 32'hFF,
                              32'h7FFF, 32'h8000, 32'hFFFF, 32'h7FFF_FFFF,
                              32'h8000_0000, 32'd3};
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, zero divisor, halves, all types
    for (int t = 0; t < 8; t++) begin
      write_reg(pdss_pkg::REG_PIXEL_TYPE, 32'(t));
      write_reg(pdss_pkg::REG_SCALE_FACTOR,
                (t == 4) ? 32'h8000_0000 : pdss_pkg::SCALE_RESET);
      for (int i = 0; i < 3; i++)
        send_beat(dirs[$urandom_range(0, 11)], dirs[$urandom_range(0, 11)]);
      send_beat(32'd0, 32'd0);
      send_beat(32'd5, 32'd0);
      send_beat(32'd1, 32'd2);
      send_beat(32'hFFFF_FFFF, 32'd2);
      drain();
    end
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(pdss_pkg::REG_PIXEL_TYPE, $urandom_range(0, 7));
      write_reg(pdss_pkg::REG_SCALE_FACTOR, pick_scale());
      if (ph == 11) calm = 1;
      for (int i = 0; i < 140; i++) send_beat(pick(), pick());
      drain();
    end
    if (sb.pending.size() != 0) report("results left over");
    if (errors == 0) $display("pixel_divide_scale_saturate: match");
    else $display("pixel_divide_scale_saturate: mismatch");
    $finish;
  end

  initial begin
    #2000000;
    $display("pixel_divide_scale_saturate: mismatch");
    $finish;
  end
endmodule
